@@ src/wcwm_pkg.sv @@
// Shared types, codes and helpers of the word concatenation window matcher.
// No dependencies; every other file of the block but wcwm_ram imports this package.
package wcwm_pkg;

    localparam int KEY_W   = 64;
    localparam int CH_W    = 8;
    localparam int LEN_W   = 4;
    localparam int MATCH_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index taken from paddr[2]
    localparam logic REG_WORD_LEN = 1'b0;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_LOAD     = 2'd1,
        ACT_NEW_TEXT = 2'd2,
        ACT_CHAR     = 2'd3
    } action_t;

    typedef struct packed {
        logic clear;
        logic load;
    } dict_cmd_t;

    // Length in use: zero acts as one, anything above the maximum as the maximum
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw,
                                                 input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] r;
        r = raw;
        if (raw == '0) r = LEN_W'(1);
        else if (raw > max_len) r = max_len;
        return r;
    endfunction

    // Keep the low len bytes of a word
    function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_W-1:0] w,
                                                  input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        if (len >= LEN_W'(8)) m = '1;
        else m = ~({KEY_W{1'b1}} << {len[2:0], 3'b000});
        return w & m;
    endfunction

    // Take the last len characters of the history word, oldest lowest
    function automatic logic [KEY_W-1:0] key_tail(input logic [KEY_W-1:0] recent,
                                                  input logic [LEN_W-1:0] len);
        logic [2:0] back;
        back = 3'(LEN_W'(8) - len);
        return recent >> {back, 3'b000};
    endfunction

endpackage

@@ src/wcwm_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read-first on a same-address collision. Uses no package items.
module wcwm_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end
endmodule

@@ src/wcwm_dict.sv @@
// Word table: distinct keys with their need counts, lookup and load logic.
// Depends on wcwm_pkg.
module wcwm_dict #(
    parameter int WORD_SLOTS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  wcwm_pkg::dict_cmd_t                           cmd,
    input  logic [wcwm_pkg::KEY_W-1:0]                    key,
    output logic                                          hit,
    output logic [(WORD_SLOTS > 1 ? $clog2(WORD_SLOTS) : 1)-1:0] id,
    input  logic [(WORD_SLOTS > 1 ? $clog2(WORD_SLOTS) : 1)-1:0] need_idx,
    output logic [$clog2(WORD_SLOTS+1)-1:0]               need_q,
    output logic [$clog2(WORD_SLOTS+1)-1:0]               total_q,
    output logic [$clog2(WORD_SLOTS+1)-1:0]               total_next
);
    import wcwm_pkg::*;

    localparam int ID_W   = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int NEED_W = $clog2(WORD_SLOTS + 1);

    logic [KEY_W-1:0]  keys_reg [WORD_SLOTS];
    logic [NEED_W-1:0] need_reg [WORD_SLOTS];
    logic [NEED_W-1:0] distinct_reg;
    logic [NEED_W-1:0] total_reg;
    logic              room;

    // Match the key against every filled slot
    always_comb begin
        hit = 1'b0;
        id  = '0;
        for (int s = 0; s < WORD_SLOTS; s++) begin
            if (!hit && (NEED_W'(s) < distinct_reg) && (keys_reg[s] == key)) begin
                hit = 1'b1;
                id  = ID_W'(s);
            end
        end
    end

    assign room    = (total_reg < NEED_W'(WORD_SLOTS));
    assign need_q  = need_reg[need_idx];
    assign total_q = total_reg;

    // Total after this cycle's command
    always_comb begin
        total_next = total_reg;
        if (cmd.clear) begin
            total_next = '0;
        end else if (cmd.load && room && (hit || distinct_reg < NEED_W'(WORD_SLOTS))) begin
            total_next = total_reg + NEED_W'(1);
        end
    end

    // Counts and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            distinct_reg <= '0;
            total_reg    <= '0;
            for (int s = 0; s < WORD_SLOTS; s++) begin
                need_reg[s] <= '0;
            end
        end else if (cmd.load && room) begin
            if (hit) begin
                need_reg[id] <= need_reg[id] + NEED_W'(1);
                total_reg    <= total_next;
            end else if (distinct_reg < NEED_W'(WORD_SLOTS)) begin
                need_reg[ID_W'(distinct_reg)] <= NEED_W'(1);
                distinct_reg <= distinct_reg + NEED_W'(1);
                total_reg    <= total_next;
            end
        end
    end

    // Key store, no reset
    always_ff @(posedge aclk) begin
        if (aresetn && !cmd.clear && cmd.load && room && !hit
            && distinct_reg < NEED_W'(WORD_SLOTS)) begin
            keys_reg[ID_W'(distinct_reg)] <= key;
        end
    end
endmodule

@@ src/word_concatenation_window_matcher_top.sv @@
// Top level of the word concatenation window matcher: request intake, the
// three-stage count pipeline over two RAMs, and the result queue.
// Depends on wcwm_pkg, wcwm_dict and wcwm_ram.
//
//  port group   direction  contents
//  s_*          in         request: action, word_bits, ch (valid/ready)
//  m_*          out        result: match_start (valid/ready)
//  p*           in/out     APB register port, word_len at byte address 0
//
// A text character is looked up in stage A, its word is added to the phase
// count in stage B and the word leaving the window is removed in stage C; the
// next character can enter stage A as the previous one is in stage C, as the
// count RAM has a single read port. A result is queued from stage C. Clear,
// load and new-text requests take one cycle and wait until the pipeline is
// empty. Reset is synchronous. A stalled result queue holds back new
// characters only.
module word_concatenation_window_matcher_top #(
    parameter int WORD_SLOTS    = 16,
    parameter int WORD_BYTES    = 8,
    parameter int TEXT_POS_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [wcwm_pkg::KEY_W-1:0]      s_word_bits,
    input  logic [wcwm_pkg::CH_W-1:0]       s_ch,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wcwm_pkg::MATCH_W-1:0]    m_match_start,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wcwm_pkg::PADDR_W-1:0]    paddr,
    input  logic [wcwm_pkg::PDATA_W-1:0]    pwdata,
    output logic [wcwm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import wcwm_pkg::*;

    localparam int ID_W      = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int NEED_W    = $clog2(WORD_SLOTS + 1);
    localparam int CNT_W     = $clog2(WORD_SLOTS + 2);
    localparam int PH_W      = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int HIST_D    = WORD_SLOTS * WORD_BYTES;
    localparam int HIST_AW   = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int CNT_AW    = PH_W + ID_W;
    localparam int CNT_D     = 1 << CNT_AW;
    localparam int POS_W     = TEXT_POS_BITS + 1;
    localparam int SPAN_W    = NEED_W + LEN_W;
    localparam int CW        = ((POS_W > SPAN_W) ? POS_W : SPAN_W) + 1;
    localparam int FIFO_D    = 4;
    localparam int FP_W      = 2;
    localparam int FC_W      = 3;

    // Configuration register
    logic [LEN_W-1:0] word_len_reg;
    logic             cfg_wr;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_new;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WORD_LEN);
    assign prdata = (paddr[2] == REG_WORD_LEN) ? PDATA_W'(word_len_reg) : '0;
    assign len_eff = eff_len(word_len_reg, LEN_W'(WORD_BYTES));
    assign len_new = cfg_wr ? eff_len(pwdata[LEN_W-1:0], LEN_W'(WORD_BYTES)) : len_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg <= LEN_W'(1);
        end else if (cfg_wr) begin
            word_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Pipeline stage registers
    logic                a_vld_reg, b_vld_reg, c_vld_reg;
    logic                a_act_reg, b_act_reg, c_act_reg;
    logic                a_rem_reg, b_rem_reg, c_rem_reg;
    logic [PH_W-1:0]     a_ph_reg, b_ph_reg, c_ph_reg;
    logic [POS_W-1:0]    a_q1_reg, b_q1_reg, c_q1_reg;
    logic [HIST_AW-1:0]  a_wptr_reg;
    logic                b_hit_reg;
    logic [ID_W-1:0]     b_id_reg, c_oid_reg;
    logic [NEED_W-1:0]   c_miss_reg;

    // Text state
    logic [POS_W-1:0]    pos_reg;
    logic [KEY_W-1:0]    recent_reg, key_reg;
    logic [PH_W-1:0]     ph_reg;
    logic [HIST_AW-1:0]  wptr_reg;
    logic [NEED_W-1:0]   miss_reg [WORD_BYTES];
    logic [CNT_D-1:0]    cnt_vld_reg;

    // Result queue
    logic [MATCH_W-1:0]  fifo_reg [FIFO_D];
    logic [FP_W-1:0]     fifo_wp_reg, fifo_rp_reg;
    logic [FC_W-1:0]     fifo_cnt_reg;

    // Request decode
    logic s_acc, is_char, start_text, char_live, credit_ok;
    logic [FC_W-1:0] inflight;
    dict_cmd_t dcmd;

    assign is_char   = (action_t'(s_action) == ACT_CHAR);
    assign inflight  = FC_W'(a_vld_reg) + FC_W'(b_vld_reg) + FC_W'(c_vld_reg);
    assign credit_ok = (fifo_cnt_reg + inflight) < FC_W'(FIFO_D);
    assign s_ready   = !a_vld_reg && (is_char ? credit_ok : (!b_vld_reg && !c_vld_reg));
    assign s_acc     = s_valid && s_ready;
    assign dcmd.clear = s_acc && (action_t'(s_action) == ACT_CLEAR);
    assign dcmd.load  = s_acc && (action_t'(s_action) == ACT_LOAD);
    assign start_text = s_acc && !is_char || cfg_wr;
    assign char_live  = s_acc && is_char && !pos_reg[POS_W-1];

    // Word table
    logic [KEY_W-1:0]  lkey;
    logic              lhit;
    logic [ID_W-1:0]   lid, need_idx;
    logic [NEED_W-1:0] need_q, total_q, total_next;

    assign lkey     = a_vld_reg ? key_reg : key_mask(s_word_bits, len_eff);
    assign need_idx = c_vld_reg ? c_oid_reg : b_id_reg;

    wcwm_dict #(.WORD_SLOTS(WORD_SLOTS)) u_dict (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dcmd),
        .key        (lkey),
        .hit        (lhit),
        .id         (lid),
        .need_idx   (need_idx),
        .need_q     (need_q),
        .total_q    (total_q),
        .total_next (total_next)
    );

    // Window span and the history slot it points back to
    logic [SPAN_W-1:0]  span;
    logic [HIST_AW-1:0] back;
    logic [HIST_AW:0]   rptr_w;
    logic [HIST_AW-1:0] rptr;
    logic [CW-1:0]      q1_w, lim_w;
    logic [KEY_W-1:0]   recent_next;

    assign span  = SPAN_W'(total_q) * SPAN_W'(len_eff);
    assign back  = (span >= SPAN_W'(HIST_D)) ? '0 : HIST_AW'(span);
    assign rptr_w = ((HIST_AW+1)'(a_wptr_reg) >= (HIST_AW+1)'(back))
                  ? (HIST_AW+1)'(a_wptr_reg) - (HIST_AW+1)'(back)
                  : (HIST_AW+1)'(a_wptr_reg) + (HIST_AW+1)'(HIST_D) - (HIST_AW+1)'(back);
    assign rptr  = HIST_AW'(rptr_w);
    assign q1_w  = CW'(pos_reg) + CW'(1);
    assign lim_w = CW'(span) + CW'(len_eff);
    assign recent_next = {s_ch, recent_reg[KEY_W-1:CH_W]};

    // History RAM: {known, id} per position
    logic [ID_W:0] hist_q;
    logic          a_hit;

    assign a_hit = a_act_reg && lhit;

    wcwm_ram #(.DEPTH(HIST_D), .WIDTH(ID_W + 1)) u_hist (
        .aclk  (aclk),
        .we    (a_vld_reg),
        .waddr (a_wptr_reg),
        .wdata ({a_hit, lid}),
        .raddr (rptr),
        .rdata (hist_q)
    );

    // Count RAM holds the word counts of each phase window; invalid entries read zero
    logic [CNT_AW-1:0] cnt_raddr, cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_ram_q, cnt_q;
    logic              cnt_we;
    logic              fwd_hit_reg, rd_vld_reg;
    logic [CNT_W-1:0]  fwd_data_reg;
    logic              out_known, rem_do;
    logic [CNT_W-1:0]  used1, used2;
    logic [NEED_W-1:0] miss0, miss1, miss2;

    assign out_known = hist_q[ID_W];
    assign rem_do    = b_vld_reg && b_rem_reg && out_known;
    assign cnt_raddr = a_vld_reg ? {a_ph_reg, lid} : {b_ph_reg, hist_q[ID_W-1:0]};
    assign cnt_q     = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? cnt_ram_q : '0);

    // Stage B adds the incoming word, stage C removes the outgoing one
    assign miss0 = miss_reg[b_ph_reg];
    assign used1 = cnt_q + CNT_W'(1);
    assign miss1 = (b_hit_reg && cnt_q < CNT_W'(need_q)) ? miss0 - NEED_W'(1) : miss0;
    assign used2 = cnt_q - CNT_W'(1);
    assign miss2 = (c_rem_reg && used2 < CNT_W'(need_q)) ? c_miss_reg + NEED_W'(1)
                                                          : c_miss_reg;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = {b_ph_reg, b_id_reg};
        cnt_wdata = used1;
        if (b_vld_reg && b_hit_reg) begin
            cnt_we = 1'b1;
        end else if (c_vld_reg && c_rem_reg) begin
            cnt_we    = 1'b1;
            cnt_waddr = {c_ph_reg, c_oid_reg};
            cnt_wdata = used2;
        end
    end

    wcwm_ram #(.DEPTH(CNT_D), .WIDTH(CNT_W)) u_cnt (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_ram_q)
    );

    // Forward a write that lands on the entry being read
    always_ff @(posedge aclk) begin
        fwd_hit_reg  <= cnt_we && (cnt_waddr == cnt_raddr);
        fwd_data_reg <= cnt_wdata;
        rd_vld_reg   <= cnt_vld_reg[cnt_raddr];
    end

    // Entry valid bits: drop all at a new text
    always_ff @(posedge aclk) begin
        if (!aresetn || start_text) begin
            cnt_vld_reg <= '0;
        end else if (cnt_we) begin
            cnt_vld_reg[cnt_waddr] <= 1'b1;
        end
    end

    // Text position, recent characters, phase and history pointer
    always_ff @(posedge aclk) begin
        if (!aresetn || start_text) begin
            pos_reg    <= '0;
            recent_reg <= '0;
            ph_reg     <= (len_new == LEN_W'(1)) ? '0 : PH_W'(1);
            wptr_reg   <= '0;
        end else if (char_live) begin
            pos_reg    <= pos_reg + POS_W'(1);
            recent_reg <= recent_next;
            ph_reg <= (LEN_W'(ph_reg) + LEN_W'(1) == len_eff) ? '0 : ph_reg + PH_W'(1);
            wptr_reg <= (wptr_reg == HIST_AW'(HIST_D - 1)) ? '0 : wptr_reg + HIST_AW'(1);
        end
    end

    // Phase missing counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < WORD_BYTES; p++) miss_reg[p] <= '0;
        end else if (start_text) begin
            for (int p = 0; p < WORD_BYTES; p++) miss_reg[p] <= total_next;
        end else if (c_vld_reg && c_act_reg) begin
            miss_reg[c_ph_reg] <= miss2;
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= char_live;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (char_live) begin
            key_reg    <= key_tail(recent_next, len_eff);
            a_act_reg  <= q1_w >= CW'(len_eff);
            a_rem_reg  <= (q1_w >= lim_w) && (total_q != '0);
            a_ph_reg   <= ph_reg;
            a_q1_reg   <= POS_W'(q1_w);
            a_wptr_reg <= wptr_reg;
        end
        b_act_reg  <= a_act_reg;
        b_hit_reg  <= a_hit;
        b_id_reg   <= lid;
        b_rem_reg  <= a_rem_reg;
        b_ph_reg   <= a_ph_reg;
        b_q1_reg   <= a_q1_reg;
        c_act_reg  <= b_act_reg;
        c_rem_reg  <= rem_do;
        c_oid_reg  <= hist_q[ID_W-1:0];
        c_ph_reg   <= b_ph_reg;
        c_q1_reg   <= b_q1_reg;
        c_miss_reg <= miss1;
    end

    // Result queue
    logic push, pop;
    logic [CW-1:0] start_w;

    assign start_w = CW'(c_q1_reg) - CW'(span);
    assign push    = c_vld_reg && c_act_reg && (total_q != '0) && (miss2 == '0);
    assign pop     = m_valid && m_ready;
    assign m_valid = (fifo_cnt_reg != '0);
    assign m_match_start = fifo_reg[fifo_rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wp_reg  <= '0;
            fifo_rp_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) fifo_wp_reg <= fifo_wp_reg + FP_W'(1);
            if (pop)  fifo_rp_reg <= fifo_rp_reg + FP_W'(1);
            fifo_cnt_reg <= fifo_cnt_reg + FC_W'(push) - FC_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[fifo_wp_reg] <= MATCH_W'(start_w);
        end
    end
endmodule

@@ tb/wcwm_checker.sv @@
// Scoreboard of the word concatenation window matcher: watches the request,
// result and register ports, predicts each match start and compares.
// Depends on wcwm_pkg only.
module wcwm_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [wcwm_pkg::KEY_W-1:0]   s_word_bits,
    input  logic [wcwm_pkg::CH_W-1:0]    s_ch,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [wcwm_pkg::MATCH_W-1:0] m_match_start,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wcwm_pkg::PADDR_W-1:0] paddr,
    input  logic [wcwm_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending,
    output int                           match_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wcwm_pkg::*;

    localparam int SLOTS    = 16;
    localparam int MAXLEN   = 8;
    localparam int HIST     = SLOTS * MAXLEN;
    localparam int POS_LIMIT = 1 << 16;

    // Predicted state of the block
    logic [LEN_W-1:0]   len_reg;
    logic [KEY_W-1:0]   dict_key [SLOTS];
    int                 dict_need [SLOTS];
    int                 n_distinct;
    int                 n_total;
    int                 win_count [MAXLEN][SLOTS];
    int                 win_missing [MAXLEN];
    int                 pos_word [HIST];
    logic [KEY_W-1:0]   char_window;
    int                 text_pos;

    logic [MATCH_W-1:0] expected_starts [$];

    function automatic int cur_len();
        if (len_reg == 0) return 1;
        if (len_reg > MAXLEN) return MAXLEN;
        return int'(len_reg);
    endfunction

    function automatic void restart_text();
        for (int p = 0; p < MAXLEN; p++) begin
            for (int s = 0; s < SLOTS; s++) win_count[p][s] = dict_need[s];
            win_missing[p] = n_total;
        end
        for (int h = 0; h < HIST; h++) pos_word[h] = -1;
        char_window = '0;
        text_pos = 0;
    endfunction

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int s = 0; s < n_distinct; s++)
            if (dict_key[s] == key) return s;
        return -1;
    endfunction

    function automatic void clear_dict();
        for (int s = 0; s < SLOTS; s++) begin
            dict_key[s] = '0;
            dict_need[s] = 0;
        end
        n_distinct = 0;
        n_total = 0;
        restart_text();
    endfunction

    // Advance the prediction by one accepted request
    function automatic void take_request(logic [1:0] act, logic [KEY_W-1:0] wb,
                                         logic [CH_W-1:0] c);
        int len, id, ph, span, oid;
        logic [KEY_W-1:0] key, mask;
        len = cur_len();
        case (action_t'(act))
            ACT_CLEAR: clear_dict();
            ACT_LOAD: begin
                mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
                key = wb & mask;
                if (n_total < SLOTS) begin
                    id = find_key(key);
                    if (id >= 0) begin
                        dict_need[id]++;
                        n_total++;
                    end else if (n_distinct < SLOTS) begin
                        dict_key[n_distinct] = key;
                        dict_need[n_distinct] = 1;
                        n_distinct++;
                        n_total++;
                    end
                end
                restart_text();
            end
            ACT_NEW_TEXT: restart_text();
            ACT_CHAR: begin
                if (text_pos < POS_LIMIT) begin
                    char_window = {c, char_window[KEY_W-1:8]};
                    if (text_pos + 1 >= len) begin
                        key = char_window >> (64 - 8 * len);
                        id = find_key(key);
                        ph = (text_pos + 1) % len;
                        span = n_total * len;
                        if (id >= 0) begin
                            if (win_count[ph][id] > 0) win_missing[ph]--;
                            win_count[ph][id]--;
                        end
                        // drop the word leaving this phase's window
                        if (text_pos + 1 >= span + len) begin
                            oid = pos_word[(text_pos - span) % HIST];
                            if (oid >= 0) begin
                                win_count[ph][oid]++;
                                if (win_count[ph][oid] > 0) win_missing[ph]++;
                            end
                        end
                        pos_word[text_pos % HIST] = id;
                        text_pos++;
                        if (n_total > 0 && win_missing[ph] == 0)
                            expected_starts = {expected_starts, MATCH_W'(text_pos - span)};
                    end else begin
                        pos_word[text_pos % HIST] = -1;
                        text_pos++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    assign pending = expected_starts.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            len_reg = LEN_W'(1);
            clear_dict();
            expected_starts.delete();
            fail_count <= 0;
            match_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_WORD_LEN) begin
                len_reg = pwdata[LEN_W-1:0];
                restart_text();
            end
            if (s_valid && s_ready)
                take_request(s_action, s_word_bits, s_ch);
            // compare each result with the oldest expectation
            if (m_valid && m_ready) begin
                match_count <= match_count + 1;
                if (expected_starts.size() == 0) begin
                    $error("match_start expected none got %0d", m_match_start);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_match_start !== expected_starts[0]) begin
                        $error("match_start expected %0d got %0d",
                               expected_starts[0], m_match_start);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_starts.pop_front());
                end
            end
        end
    end

endmodule

@@ tb/word_concatenation_window_matcher_top_tb.sv @@
// Stimulus and verdict for the word concatenation window matcher top level.
// Depends on wcwm_pkg, the block's RTL and wcwm_checker.
module word_concatenation_window_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wcwm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_action;
    logic [KEY_W-1:0]     s_word_bits;
    logic [CH_W-1:0]      s_ch;
    logic                 m_valid;
    logic                 m_ready;
    logic [MATCH_W-1:0]   m_match_start;
    logic                 psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata, prdata;

    int fail_count, pending, match_count;
    int send_idle_pct, recv_idle_pct;
    bit hold_results;
    int request_count;
    int tb_len;
    logic [KEY_W-1:0] loaded_words [$];

    word_concatenation_window_matcher_top dut (.*);

    wcwm_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: random back-pressure, or a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("word_concatenation_window_matcher_top test failed");
                $finish;
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send(logic [1:0] act, logic [KEY_W-1:0] wb, logic [CH_W-1:0] c);
        bit rdy;
        s_valid <= 1'b1;
        s_action <= act;
        s_word_bits <= wb;
        s_ch <= c;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        request_count++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Pause the sender until every expected match has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_len(int raw);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_WORD_LEN, 2'b00};
        pwdata <= PDATA_W'(raw);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        tb_len = (raw % 16 == 0) ? 1 : ((raw % 16 > 8) ? 8 : raw % 16);
        loaded_words.delete();
    endtask

    function automatic logic [CH_W-1:0] pick_char();
        if ($urandom_range(99) < 85) return ($urandom_range(1)) ? "a" : "b";
        return CH_W'($urandom_range(255));
    endfunction

    task automatic load_word(logic [KEY_W-1:0] w);
        logic [KEY_W-1:0] mask;
        mask = (tb_len >= 8) ? '1 : ((64'd1 << (8 * tb_len)) - 64'd1);
        send(ACT_LOAD, w, CH_W'($urandom));
        loaded_words = {loaded_words, w & mask};
    endtask

    task automatic send_word(logic [KEY_W-1:0] w);
        for (int b = 0; b < tb_len; b++) send(ACT_CHAR, {$urandom, $urandom}, w[8*b +: 8]);
    endtask

    // One round: fresh dictionary, then text made mostly of loaded words
    task automatic run_round();
        int n_words, n_text;
        logic [KEY_W-1:0] w;
        if ($urandom_range(3) == 0) write_len($urandom_range(15));
        send(ACT_CLEAR, {$urandom, $urandom}, CH_W'($urandom));
        loaded_words.delete();
        n_words = ($urandom_range(9) < 3) ? $urandom_range(14, 18) : $urandom_range(1, 5);
        for (int i = 0; i < n_words; i++) begin
            if (i > 0 && $urandom_range(2) == 0)
                w = loaded_words[$urandom_range(loaded_words.size() - 1)];
            else
                for (int b = 0; b < 8; b++) w[8*b +: 8] = pick_char();
            // garbage above the word length must be ignored
            if ($urandom_range(1)) w = w | ({$urandom, $urandom} << (8 * tb_len));
            load_word(w);
        end
        n_text = $urandom_range(4, 30);
        for (int i = 0; i < n_text; i++) begin
            case ($urandom_range(19))
                0: send(ACT_CHAR, {$urandom, $urandom}, pick_char());
                1: send(ACT_NEW_TEXT, {$urandom, $urandom}, CH_W'($urandom));
                2: send(2'($urandom), {$urandom, $urandom}, CH_W'($urandom));
                default: send_word(loaded_words[$urandom_range(loaded_words.size() - 1)]);
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_CLEAR;
        s_word_bits = '0;
        s_ch = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_results = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        request_count = 0;
        tb_len = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, field extremes, all actions, length limits
        send(ACT_CHAR, '0, 8'hff);
        send(ACT_LOAD, '1, 8'h00);
        send(ACT_LOAD, '0, 8'hff);
        send(ACT_NEW_TEXT, '1, '0);
        send(ACT_CHAR, '0, 8'hff);
        send(ACT_CHAR, '0, 8'h00);
        send(ACT_CHAR, '1, 8'h00);
        send(ACT_CLEAR, '1, 8'hff);
        send(ACT_CHAR, '0, 8'h00);
        write_len(0);
        load_word(64'h61);
        send(ACT_CHAR, '0, "a");
        send(ACT_CHAR, '0, "z");
        write_len(15);
        load_word(64'h6867_6665_6463_6261);
        load_word(64'hffff_ffff_ffff_ffff);
        send_word(64'hffff_ffff_ffff_ffff);
        send_word(64'h6867_6665_6463_6261);
        write_len(8);
        send(ACT_CLEAR, '0, '0);
        for (int i = 0; i < 17; i++) load_word(64'h0102_0304_0506_0708 + i % 3);
        drain();

        // Random rounds under three idling patterns
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 23 : ((m == 1) ? 69 : 0);
            recv_idle_pct = (m == 0) ? 69 : ((m == 1) ? 23 : 0);
            while (request_count < 50 + 533 * (m + 1)) run_round();
        end

        // Hold results off while a match on every character backs up
        write_len(1);
        send(ACT_CLEAR, '0, '0);
        load_word(64'h61);
        hold_results = 1'b1;
        for (int i = 0; i < 100; i++) send(ACT_CHAR, '0, "a");
        drain();
        repeat (20) @(posedge aclk);

        if (pending != 0) $error("%0d expected matches never arrived", pending);
        $display("Covered %0d requests and %0d matches over word lengths 1 to 8,",
                 request_count, match_count);
        $display("table overflow, repeated words and a long stall of the results.");
        if (fail_count == 0 && pending == 0) begin
            $display("word_concatenation_window_matcher_top test passed");
        end else begin
            $display("word_concatenation_window_matcher_top test failed");
        end
        $finish;
    end

endmodule
